// File: src/dpf_pkg.sv
// Package for the duplicate packet filter: table entry type, outcome codes,
// register map and the command/status structs between controller and datapath.
// No dependencies.
package dpf_pkg;

  localparam int unsigned SENDER_W  = 32;
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TIMEOUT_W = 16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_FRESH_TIMEOUT   = 3'd0;
  localparam logic [TIMEOUT_W-1:0]  FRESH_TIMEOUT_RESET = 16'd30;

  typedef enum logic [1:0] {
    OUT_DUPLICATE = 2'd0,
    OUT_UPDATED   = 2'd1,
    OUT_INSERTED  = 2'd2,
    OUT_FULL      = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [SEQ_W-1:0]    seq;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic     in_ready;
    logic     load;
    logic     advance;
    logic     write;
    logic     result_load;
    outcome_t result_code;
  } dpf_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic match;
    logic dup;
    logic empty;
    logic last;
    logic out_busy;
  } dpf_status_t;

endpackage

// File: src/dpf_if.sv
// Handshake channel interfaces for the duplicate packet filter: the packet
// channel and the verdict channel. Each carries valid, ready and its payload.
interface dpf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sender_id;
  logic [15:0] sequence_number;
  logic [31:0] now_seconds;

  modport source (output valid, output sender_id, output sequence_number,
                  output now_seconds, input ready);
  modport sink   (input valid, input sender_id, input sequence_number,
                  input now_seconds, output ready);
endinterface

interface dpf_out_if;
  logic       valid;
  logic       ready;
  logic       is_fresh;
  logic [1:0] outcome;

  modport source (output valid, output is_fresh, output outcome, input ready);
  modport sink   (input valid, input is_fresh, input outcome, output ready);
endinterface

// File: src/dpf_regs.sv
// APB-style configuration register block holding the freshness timeout.
// Depends on dpf_pkg.
module dpf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dpf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dpf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [dpf_pkg::TIMEOUT_W-1:0]   fresh_timeout
);
  import dpf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_FRESH_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_timeout <= FRESH_TIMEOUT_RESET;
    end else if (wr_en) begin
      fresh_timeout <= pwdata[TIMEOUT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == REG_FRESH_TIMEOUT) begin
      prdata = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, fresh_timeout};
    end else begin
      prdata = '0;
    end
  end

endmodule

// File: src/dpf_ctrl.sv
// Controller state machine of the duplicate packet filter: sequences the
// table scan and the result hand-off. Depends on dpf_pkg.
module dpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  dpf_pkg::dpf_status_t status,
  output dpf_pkg::dpf_cmd_t    cmd
);
  import dpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t   state, state_next;
  outcome_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= OUT_FULL;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next      = state;
    code_next       = code;
    cmd             = '0;
    cmd.result_code = code;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.match) begin
          cmd.write  = 1'b1;
          code_next  = status.dup ? OUT_DUPLICATE : OUT_UPDATED;
          state_next = S_DONE;
        end else if (status.empty) begin
          cmd.write  = 1'b1;
          code_next  = OUT_INSERTED;
          state_next = S_DONE;
        end else if (status.last) begin
          code_next  = OUT_FULL;
          state_next = S_DONE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/dpf_datapath.sv
// Datapath of the duplicate packet filter: packet latch, scan index, entry
// memory with per-entry valid bits, compare logic and result register.
// Depends on dpf_pkg and the channel interfaces in dpf_if.sv.
module dpf_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  dpf_in_if.sink                         in_ch,
  dpf_out_if.source                      out_ch,
  input  logic [dpf_pkg::TIMEOUT_W-1:0]  fresh_timeout,
  input  dpf_pkg::dpf_cmd_t              cmd,
  output dpf_pkg::dpf_status_t           status
);
  import dpf_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;

  entry_t              cur;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_entry;
  logic                rd_valid;
  entry_t              eff;
  logic [TIME_W:0]     limit;

  logic     out_valid;
  logic     out_fresh;
  outcome_t out_code;

  assign in_ch.ready = cmd.in_ready;

  // Packet latch and scan index.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.sender <= in_ch.sender_id;
      cur.seq    <= in_ch.sequence_number;
      cur.stamp  <= in_ch.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= idx + 1'b1;
    end
  end

  // Read one entry ahead of the compare so the scan covers one entry a cycle.
  always_comb begin
    if (cmd.load || idx == LAST_IDX) begin
      rd_addr = '0;
    end else begin
      rd_addr = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
    if (cmd.write) begin
      mem[idx] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= vld[rd_addr];
      if (cmd.write) begin
        vld[idx] <= 1'b1;
      end
    end
  end

  // An entry never written reads as empty.
  assign eff   = rd_valid ? rd_entry : '0;
  assign limit = {1'b0, eff.stamp} + {{(TIME_W+1-TIMEOUT_W){1'b0}}, fresh_timeout};

  assign status.in_valid = in_ch.valid;
  assign status.match    = (eff.sender == cur.sender);
  assign status.dup      = (eff.seq == cur.seq) && ({1'b0, cur.stamp} < limit);
  assign status.empty    = (eff.sender == '0);
  assign status.last     = (idx == LAST_IDX);
  assign status.out_busy = out_valid && !out_ch.ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_code  <= cmd.result_code;
      out_fresh <= (cmd.result_code != OUT_DUPLICATE);
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.is_fresh = out_fresh;
  assign out_ch.outcome  = out_code;

endmodule

// File: src/duplicate_packet_filter_top.sv
// Top level of the duplicate packet filter: joins the register block, the
// controller and the datapath. Depends on dpf_pkg, dpf_if, dpf_regs,
// dpf_ctrl and dpf_datapath.
//
// Usage: packets enter on in_ch as beats carrying sender_id, sequence_number
// and now_seconds. For every packet beat exactly one verdict beat leaves on
// out_ch with is_fresh (1 keep, 0 drop) and outcome (duplicate, updated,
// inserted, table full). The freshness timeout in seconds sits at APB byte
// address 0; the user writes it only while idle; the block does not check.
// Operation: the block works on one packet at a time. After the
// accepting edge the table is scanned one entry per cycle from index 0, the
// scan being set by the single read port of the entry memory. The scan stops
// at the first entry whose sender matches or that is empty, or at the last
// entry; the verdict register is then loaded once it is free, and only after
// that can a new packet be taken.
// Reset: rst clears the per-entry valid bits, which empties the whole table,
// and sets the timeout back to 30 seconds. No clearing pass.
// Stalls: the verdict register holds its beat while out_ch.ready is low. The
// next packet can be scanned meanwhile, but its verdict waits until the held
// beat is taken, and no further packet is accepted until then.
module duplicate_packet_filter_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  dpf_in_if.sink                          in_ch,
  dpf_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dpf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dpf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import dpf_pkg::*;

  logic [TIMEOUT_W-1:0] fresh_timeout;
  dpf_cmd_t             cmd;
  dpf_status_t          status;

  // Configuration registers.
  dpf_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fresh_timeout (fresh_timeout)
  );

  // Scan sequencer: issues load, advance, write and result commands.
  dpf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Entry table, compare logic and verdict register.
  dpf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fresh_timeout (fresh_timeout),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// File: test/dpf_checker.sv
// Scoreboard for the duplicate packet filter: tracks the sender table and the timeout
// register, predicts one verdict per packet beat and compares verdict beats in order.
// Depends on dpf_pkg and the channel interfaces in dpf_if.
module dpf_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  dpf_in_if                              pkt_mon,
  dpf_out_if                             verdict_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [dpf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dpf_pkg::APB_DATA_W-1:0] pwdata,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpf_pkg::*;

  typedef struct packed {
    logic     is_fresh;
    outcome_t outcome;
  } verdict_t;

  logic [SENDER_W-1:0]  tab_sender [TABLE_ENTRIES];
  logic [SEQ_W-1:0]     tab_seq    [TABLE_ENTRIES];
  logic [TIME_W-1:0]    tab_stamp  [TABLE_ENTRIES];
  logic [TIMEOUT_W-1:0] timeout_s;
  verdict_t             verdict_q[$];

  // Scan the table in index order; a sender match is tested before the empty
  // test, so sender zero lands on the first empty slot without claiming it.
  function automatic verdict_t filter_packet(input logic [SENDER_W-1:0] who,
                                             input logic [SEQ_W-1:0] seq,
                                             input logic [TIME_W-1:0] now);
    verdict_t          v;
    logic              hit;
    logic [TIME_W:0]   limit;
    v   = '{is_fresh: 1'b1, outcome: OUT_FULL};
    hit = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!hit) begin
        if (tab_sender[k] == who) begin
          hit   = 1'b1;
          limit = {1'b0, tab_stamp[k]} + {{(TIME_W+1-TIMEOUT_W){1'b0}}, timeout_s};
          if (tab_seq[k] == seq && {1'b0, now} < limit) begin
            v = '{is_fresh: 1'b0, outcome: OUT_DUPLICATE};
          end else begin
            tab_seq[k] = seq;
            v = '{is_fresh: 1'b1, outcome: OUT_UPDATED};
          end
          tab_stamp[k] = now;
        end else if (tab_sender[k] == '0) begin
          hit           = 1'b1;
          tab_sender[k] = who;
          tab_seq[k]    = seq;
          tab_stamp[k]  = now;
          v = '{is_fresh: 1'b1, outcome: OUT_INSERTED};
        end
      end
    end
    return v;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        tab_sender[k] = '0;
        tab_seq[k]    = '0;
        tab_stamp[k]  = '0;
      end
      timeout_s  = FRESH_TIMEOUT_RESET;
      fail_count = 0;
      verdict_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_FRESH_TIMEOUT) begin
        timeout_s = pwdata[TIMEOUT_W-1:0];
      end
      if (pkt_mon.valid && pkt_mon.ready) begin
        verdict_q.push_back(filter_packet(pkt_mon.sender_id, pkt_mon.sequence_number,
                                          pkt_mon.now_seconds));
      end
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("verdict beat with no packet pending: is_fresh=%0b outcome=%0d",
                               verdict_mon.is_fresh, verdict_mon.outcome));
        end else begin
          want = verdict_q.pop_front();
          if (verdict_mon.is_fresh !== want.is_fresh) begin
            flag_error($sformatf("is_fresh mismatch: expected %0b, got %0b",
                                 want.is_fresh, verdict_mon.is_fresh));
          end
          if (verdict_mon.outcome !== want.outcome) begin
            flag_error($sformatf("outcome mismatch: expected %s, got %0d",
                                 want.outcome.name(), verdict_mon.outcome));
          end
        end
      end
    end
    pending <= verdict_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the duplicate packet filter: drives packet beats, the verdict
// ready and APB writes, and gives the verdict. Depends on dpf_pkg, dpf_if,
// duplicate_packet_filter_top and dpf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpf_pkg::*;

  localparam int unsigned ENTRIES       = 16;
  localparam int          CHUNKS        = 6;
  localparam int          CHUNK_ITEMS   = 215;
  localparam int          SETTLE_CYCLES = 24;
  // Cycles without any beat before the run is declared hung. A correct run
  // never comes close: one packet's work plus random gaps on either side.
  localparam int          STALL_LIMIT   = 5000;
  // Index 4 of the register map is not populated; writes there must be ignored.
  localparam logic [APB_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dpf_in_if  pkt_ch();
  dpf_out_if verdict_ch();

  int fail_count;
  int pending;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  // Stimulus state: a pool of sixteen well-known senders with their last
  // sequence numbers, and a running clock in seconds.
  logic [31:0] pool_id  [16];
  logic [15:0] pool_seq [16];
  logic [31:0] clock_s;
  logic [15:0] timeout_plan [CHUNKS];

  duplicate_packet_filter_top #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (pkt_ch),
    .out_ch (verdict_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  dpf_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .pkt_mon    (pkt_ch),
    .verdict_mon(verdict_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver drops ready at random with the current idle percentage.
  always @(posedge clk) begin
    verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any beat on either channel proves progress.
  always @(posedge clk) begin
    if (rst || (pkt_ch.valid && pkt_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // APB write: a setup cycle, then an access cycle that completes on pready.
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one packet beat, after a random gap, and hold it until accepted.
  // Valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_packet(input logic [31:0] who, input logic [15:0] seq,
                             input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_ch.valid           <= 1'b1;
    pkt_ch.sender_id       <= who;
    pkt_ch.sequence_number <= seq;
    pkt_ch.now_seconds     <= now;
    do @(posedge clk); while (!pkt_ch.ready);
  endtask

  // Let the block drain: stop offering packets, wait for every verdict, then
  // give the block its worst-case latency before touching the register.
  task automatic settle();
    pkt_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed packets, run with the reset timeout of 30 seconds. The table
  // is empty at the start, so the insert path and the sender-zero path on an
  // empty slot are both reachable here.
  task automatic run_directed();
    // All-ones sender and sequence at time zero goes into slot 0.
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    // Repeat one second before the timeout runs out: duplicate.
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'd29);
    // Exactly at stamp plus timeout: no longer a duplicate, entry updated.
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'd59);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 32'd88);
    // New sequence from a known sender always updates.
    send_packet(32'hFFFF_FFFF, 16'h0000, 32'd88);
    // Sender zero matches the empty slot 1 (sequence 0, time 0): duplicate,
    // then an update that still leaves the slot empty.
    send_packet(32'h0000_0000, 16'h0000, 32'd0);
    send_packet(32'h0000_0000, 16'h0005, 32'd100);
    // Slot 1 is still free, so sender 1 is inserted there near the top of time.
    send_packet(32'h0000_0001, 16'h0007, 32'hFFFF_FFF0);
    // Stamp plus timeout passes 2**32; the sum must not wrap.
    send_packet(32'h0000_0001, 16'h0007, 32'hFFFF_FFFF);
    // Time going backwards is still earlier than stamp plus timeout.
    send_packet(32'h0000_0001, 16'h0007, 32'd5);
    send_packet(32'h8000_0000, 16'h8000, 32'h7FFF_FFFF);
    // Same sequence long after the timeout: update.
    send_packet(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
  endtask

  // Mostly packets from the known pool with repeated sequences and a slowly
  // advancing clock, so duplicates and updates dominate. New senders fill the
  // table and later hit the full case; sender zero and clock jumps are noise.
  task automatic send_random_packet();
    int          pick;
    int          slot;
    logic [31:0] who;
    logic [15:0] seq;
    pick = $urandom_range(99);
    slot = $urandom_range(15);
    if ($urandom_range(99) < 4) begin
      clock_s = $urandom();
    end else if ($urandom_range(99) < 3) begin
      clock_s = clock_s - $urandom_range(40);
    end else begin
      clock_s = clock_s + $urandom_range(3);
    end
    if (pick < 72) begin
      who = pool_id[slot];
      seq = ($urandom_range(99) < 60) ? pool_seq[slot] : 16'($urandom());
      pool_seq[slot] = seq;
    end else if (pick < 94) begin
      who = $urandom();
      seq = 16'($urandom());
    end else begin
      who = '0;
      seq = $urandom_range(1) ? 16'h0000 : 16'($urandom());
    end
    send_packet(who, seq, clock_s);
  endtask

  initial begin
    // Every stimulus input gets a known value before the first edge.
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    pkt_ch.valid           = 1'b0;
    pkt_ch.sender_id       = '0;
    pkt_ch.sequence_number = '0;
    pkt_ch.now_seconds     = '0;
    send_idle_pct          = 32;
    recv_idle_pct          = 60;

    pool_id[0] = 32'hFFFF_FFFF;
    pool_id[1] = 32'h0000_0001;
    pool_id[2] = 32'h8000_0000;
    for (int i = 3; i < 16; i++) begin
      pool_id[i] = $urandom() | 32'h1;
    end
    for (int i = 0; i < 16; i++) begin
      pool_seq[i] = 16'($urandom());
    end
    clock_s = $urandom_range(1000);

    // Timeout settings per chunk: both extremes, the smallest nonzero value,
    // the reset value and two random ones.
    timeout_plan[0] = 16'hFFFF;
    timeout_plan[1] = 16'h0000;
    timeout_plan[2] = 16'($urandom_range(2, 120));
    timeout_plan[3] = 16'd1;
    timeout_plan[4] = 16'($urandom());
    timeout_plan[5] = FRESH_TIMEOUT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    settle();
    // The unpopulated register slot must not disturb the timeout.
    write_reg(SPARE_REG_ADDR, 32'hFFFF_FFFF);

    // Idle pattern: two chunks with a sluggish receiver, two with a sluggish
    // sender, then two at full rate on both sides.
    for (int c = 0; c < CHUNKS; c++) begin
      if (c == 2) begin
        send_idle_pct = 60;
        recv_idle_pct = 32;
      end else if (c == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Upper data bits are random; only the low 16 bits are the register.
      write_reg(REG_FRESH_TIMEOUT, {16'($urandom()), timeout_plan[c]});
      repeat (CHUNK_ITEMS) send_random_packet();
      settle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
